@@ src/tlc_pkg.sv @@
// Shared types and constants for the turnout lock controller.
// Transaction payloads, configuration, controller state and lock phase codes.
// No dependencies.
`timescale 1ns / 1ps

package tlc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_QUARTER     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_POWER_QUARTERS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELAY_POWER_QUARTERS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TIMEOUT_QUARTERS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RESTORED_POSITION     = 3'd4;

	typedef enum logic [1:0] {
		PH_LOCKED   = 2'd0,
		PH_TIMING   = 2'd1,
		PH_UNLOCKED = 2'd2
	} lock_phase_t;

	typedef struct packed {
		logic unlock_key_raw;
		logic position_key_raw;
		logic sense_normal;
		logic sense_reverse;
		logic simulate_lock;
	} tlc_in_t;

	typedef struct packed {
		logic       drive_normal;
		logic       motor_power_on;
		logic       relay_drive;
		logic       relay_power_on;
		logic       led_normal;
		logic       led_reverse;
		logic       hold_power;
		logic       store_request;
		logic       store_position;
		logic [1:0] lock_status;
	} tlc_out_t;

	typedef struct packed {
		logic [7:0] ticks_per_quarter;
		logic [7:0] motor_power_quarters;
		logic [7:0] relay_power_quarters;
		logic [7:0] lock_timeout_quarters;
		logic       restored_position;
	} tlc_cfg_t;

	// bit 0 of the key fields is the unlock key, bit 1 the position key
	typedef struct packed {
		logic [1:0]  db_low;
		logic [1:0]  db_high;
		logic [1:0]  keys;
		logic [1:0]  latches;
		logic [7:0]  prescaler;
		logic        req_pos;
		logic [7:0]  motor_timer;
		logic [7:0]  relay_timer;
		logic [7:0]  lock_timer;
		lock_phase_t phase;
		logic        relay_level;
		logic [1:0]  leds;
		logic        hold;
	} tlc_state_t;

	localparam tlc_cfg_t CFG_RESET = '{
		ticks_per_quarter:     8'd25,
		motor_power_quarters:  8'd16,
		relay_power_quarters:  8'd4,
		lock_timeout_quarters: 8'd20,
		restored_position:     1'b0
	};

	localparam tlc_state_t STATE_RESET = '{
		db_low:      2'b00,
		db_high:     2'b00,
		keys:        2'b00,
		latches:     2'b00,
		prescaler:   8'd0,
		req_pos:     1'b0,
		motor_timer: 8'd0,
		relay_timer: 8'd0,
		lock_timer:  8'd0,
		phase:       PH_LOCKED,
		relay_level: 1'b0,
		leds:        2'b11,
		hold:        1'b1
	};

endpackage

@@ src/turnout_lock_controller.sv @@
// Top level of the turnout lock controller.
// Instantiates tlc_cfg_regs and tlc_step; depends on tlc_pkg.
//
// Usage:
//  - Each input transaction is one 10 ms tick: raw key levels, the two
//    turnout sensors and the mode switch. Each tick yields exactly one
//    output transaction with drives, power enables, LED levels, hold/store
//    and lock status.
//  - Both channels use valid/ready; a transaction moves when both are high.
//  - Path: an accepted transaction waits in the input register; its result
//    then shows from the output register, if the output is not stalled.
//  - Throughput: one transaction per cycle while the output is not stalled. The
//    input register feeds the step logic, whose result lands in the output
//    register; all controller state updates in that same cycle.
//  - When the receiver stalls, hold the result in the output register and
//    keep one more tick in the input register; then drop in_ready.
//  - Configuration writes take effect at the write edge, with no wait and no
//    read-back; issue them only while no tick is in flight. A write of the
//    restored position also reloads the requested position.
//  - Reset (arst_n low): configuration returns to its defaults, controller
//    state to locked with LEDs on and hold asserted, both stages empty.
`timescale 1ns / 1ps

module turnout_lock_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  tlc_pkg::tlc_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output tlc_pkg::tlc_out_t              out_data,
	input  logic                           cfg_wr_en,
	input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tlc_pkg::*;

	tlc_cfg_t   cfg;
	logic       pos_load;

	logic       valid_s1;
	tlc_in_t    item_s1;
	logic       valid_s2;
	tlc_out_t   result_s2;

	tlc_state_t state_q;
	tlc_state_t state_next;
	tlc_out_t   result;
	logic       advance;

	tlc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.pos_load  (pos_load)
	);

	tlc_step u_step (
		.cfg    (cfg),
		.cur    (state_q),
		.item   (item_s1),
		.nxt    (state_next),
		.result (result)
	);

	// advance the held tick when the output register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register: hold the tick until the step logic consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// controller state: update once per consumed tick; otherwise a restored position write reloads req_pos
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end else if (pos_load) begin
			state_q.req_pos <= cfg_data[0];
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

@@ src/tlc_cfg_regs.sv @@
// Configuration register file of the turnout lock controller.
// Depends on tlc_pkg for the register layout and index codes.
`timescale 1ns / 1ps

module tlc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data,
	output tlc_pkg::tlc_cfg_t              cfg,
	output logic                           pos_load
);
	import tlc_pkg::*;

	tlc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_TICKS_PER_QUARTER:     cfg_q.ticks_per_quarter <= cfg_data;
				CFG_MOTOR_POWER_QUARTERS:  cfg_q.motor_power_quarters <= cfg_data;
				CFG_RELAY_POWER_QUARTERS:  cfg_q.relay_power_quarters <= cfg_data;
				CFG_LOCK_TIMEOUT_QUARTERS: cfg_q.lock_timeout_quarters <= cfg_data;
				CFG_RESTORED_POSITION:     cfg_q.restored_position <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a restored position write also reloads the requested position
	assign pos_load = cfg_wr_en && (cfg_index == CFG_RESTORED_POSITION);
	assign cfg      = cfg_q;

endmodule

@@ src/tlc_step.sv @@
// Per-tick control logic of the turnout lock controller: debounce, prescaler,
// lock machine, position toggle, power timers, LEDs and shutdown check.
// Depends on tlc_pkg; purely combinational.
`timescale 1ns / 1ps

module tlc_step (
	input  tlc_pkg::tlc_cfg_t   cfg,
	input  tlc_pkg::tlc_state_t cur,
	input  tlc_pkg::tlc_in_t    item,
	output tlc_pkg::tlc_state_t nxt,
	output tlc_pkg::tlc_out_t   result
);
	import tlc_pkg::*;

	logic motor_on;
	logic relay_on;
	logic store;

	// next state
	always_comb begin
		logic [1:0] raw;
		logic [1:0] chg;
		logic [8:0] tick_next;
		logic       quarter;
		logic       reads_normal;
		logic       reads_reverse;
		logic       matched;

		nxt = cur;

		// vertical-counter debounce, press latch on a debounced rising edge
		raw = {item.position_key_raw, item.unlock_key_raw};
		chg = cur.keys ^ raw;
		nxt.db_low  = ~(cur.db_low & chg);
		nxt.db_high = nxt.db_low ^ (cur.db_high & chg);
		chg = chg & nxt.db_low & nxt.db_high;
		nxt.keys    = cur.keys ^ chg;
		nxt.latches = cur.latches | (nxt.keys & chg);

		// quarter-second prescaler
		tick_next = {1'b0, cur.prescaler} + 9'd1;
		if (tick_next >= {1'b0, cfg.ticks_per_quarter}) begin
			nxt.prescaler = 8'd0;
			quarter       = 1'b1;
		end else begin
			nxt.prescaler = tick_next[7:0];
			quarter       = 1'b0;
		end

		reads_normal  = item.sense_normal && !item.sense_reverse;
		reads_reverse = item.sense_reverse && !item.sense_normal;

		if (item.simulate_lock) begin
			if (cur.phase == PH_LOCKED) begin
				if (nxt.latches[0]) begin
					nxt.relay_level = 1'b1;
					nxt.relay_timer = cfg.relay_power_quarters;
					nxt.lock_timer  = cfg.lock_timeout_quarters;
					nxt.phase       = PH_TIMING;
				end
				nxt.latches[0] = 1'b0;
			end else if (cur.phase == PH_UNLOCKED) begin
				if (nxt.latches[0] && reads_normal) begin
					nxt.phase       = PH_LOCKED;
					nxt.relay_level = 1'b0;
					nxt.relay_timer = cfg.relay_power_quarters;
				end
				if (nxt.latches[1]) begin
					nxt.req_pos = ~cur.req_pos;
				end
				nxt.latches = 2'b00;
			end
			// lock opens once the timeout has run out
			if (nxt.phase == PH_TIMING && nxt.lock_timer == 8'd0) begin
				nxt.latches = 2'b00;
				nxt.phase   = PH_UNLOCKED;
			end
		end else begin
			if (nxt.latches[1]) begin
				nxt.req_pos = ~cur.req_pos;
			end
			nxt.latches = 2'b00;
		end

		// sensor match against the (possibly toggled) requested position
		matched = nxt.req_pos ? reads_reverse : reads_normal;
		if (!matched) begin
			nxt.motor_timer = cfg.motor_power_quarters;
		end

		motor_on = (nxt.motor_timer != 8'd0);
		relay_on = (nxt.relay_timer != 8'd0);

		if (quarter) begin
			if (nxt.motor_timer != 8'd0) nxt.motor_timer = nxt.motor_timer - 8'd1;
			if (nxt.relay_timer != 8'd0) nxt.relay_timer = nxt.relay_timer - 8'd1;
			if (nxt.lock_timer != 8'd0)  nxt.lock_timer  = nxt.lock_timer - 8'd1;
			unique case (nxt.phase)
				PH_UNLOCKED: nxt.leds = 2'b00;
				PH_TIMING:   nxt.leds = ~nxt.leds;
				default:     nxt.leds = 2'b11;
			endcase
		end

		// shutdown: nothing powered and lock closed
		store = (nxt.motor_timer == 8'd0) && (nxt.relay_timer == 8'd0)
			&& (nxt.phase == PH_LOCKED);
		if (store) begin
			nxt.hold = 1'b0;
		end
	end

	// outputs
	always_comb begin
		result.drive_normal   = ~nxt.req_pos;
		result.motor_power_on = motor_on;
		result.relay_drive    = nxt.relay_level;
		result.relay_power_on = relay_on;
		result.led_normal     = nxt.leds[0];
		result.led_reverse    = nxt.leds[1];
		result.hold_power     = nxt.hold;
		result.store_request  = store;
		result.store_position = nxt.req_pos;
		result.lock_status    = nxt.phase;
	end

endmodule

@@ tb/sv/tb_turnout_lock_controller.sv @@
// Self-checking testbench for turnout_lock_controller: tick-level predictor,
// scoreboard class and valid/ready drivers with random idling on both sides.
// Depends on tlc_pkg and the turnout_lock_controller RTL.
`timescale 1ns / 1ps

module tb_turnout_lock_controller;

	import tlc_pkg::*;

	// generous ceiling; a correct run needs a small fraction of this
	localparam longint RUN_LIMIT_NS = 4_000_000;

	// how the turnout sensors behave during one key scene
	typedef enum {SENSE_FOLLOW, SENSE_NORMAL, SENSE_RANDOM} sense_policy_t;
	// what the operator does during one key scene
	typedef enum {SCENE_UNLOCK, SCENE_POSITION, SCENE_BOTH, SCENE_BOUNCE, SCENE_QUIET} scene_t;

	// Shadow copy of the controller: configuration, tick state and the
	// queue of outputs still owed by the block.
	class turnout_shadow;
		localparam logic [1:0] KEY_UNLOCK   = 2'b01;
		localparam logic [1:0] KEY_POSITION = 2'b10;

		logic [7:0]  quarter_ticks, motor_reload, relay_reload, lock_reload;
		logic        restore_pos;
		logic [1:0]  cnt_lo, cnt_hi, key_level, pressed;
		logic [7:0]  prescale, motor_tmr, relay_tmr, lock_tmr;
		logic        req_pos, relay_lvl, hold;
		logic [1:0]  leds;
		lock_phase_t phase;
		tlc_out_t    owed_outputs[$];
		int          errors;

		function new();
			quarter_ticks = 8'd25;
			motor_reload  = 8'd16;
			relay_reload  = 8'd4;
			lock_reload   = 8'd20;
			restore_pos   = 1'b0;
			cnt_lo        = 2'b00;
			cnt_hi        = 2'b00;
			key_level     = 2'b00;
			pressed       = 2'b00;
			prescale      = 8'd0;
			motor_tmr     = 8'd0;
			relay_tmr     = 8'd0;
			lock_tmr      = 8'd0;
			req_pos       = 1'b0;
			relay_lvl     = 1'b0;
			hold          = 1'b1;
			leds          = 2'b11;
			phase         = PH_LOCKED;
			errors        = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_TICKS_PER_QUARTER:     quarter_ticks = val;
				CFG_MOTOR_POWER_QUARTERS:  motor_reload  = val;
				CFG_RELAY_POWER_QUARTERS:  relay_reload  = val;
				CFG_LOCK_TIMEOUT_QUARTERS: lock_reload   = val;
				CFG_RESTORED_POSITION: begin
					restore_pos = val[0];
					req_pos     = val[0];
				end
				default: ;
			endcase
		endfunction

		// read and clear one press latch
		function bit take_press(logic [1:0] mask);
			bit hit;
			hit = (pressed & mask) != 2'b00;
			pressed = pressed & ~mask;
			return hit;
		endfunction

		// advance the shadow by one accepted tick and queue its outputs
		function void note_tick(tlc_in_t t);
			logic [1:0] raw, chg;
			logic [8:0] next_count;
			bit quarter, reads_normal, reads_reverse, matched;
			bit motor_on, relay_on, store, hit;
			tlc_out_t r;
			quarter = 1'b0;
			store   = 1'b0;

			// two-bit vertical counter per key
			raw       = {t.position_key_raw, t.unlock_key_raw};
			chg       = key_level ^ raw;
			cnt_lo    = ~(cnt_lo & chg);
			cnt_hi    = cnt_lo ^ (cnt_hi & chg);
			chg       = chg & cnt_lo & cnt_hi;
			key_level = key_level ^ chg;
			pressed   = pressed | (key_level & chg);

			next_count = {1'b0, prescale} + 9'd1;
			if (next_count >= {1'b0, quarter_ticks}) begin
				prescale = 8'd0;
				quarter  = 1'b1;
			end else begin
				prescale = next_count[7:0];
			end

			reads_normal  = t.sense_normal && !t.sense_reverse;
			reads_reverse = t.sense_reverse && !t.sense_normal;

			if (t.simulate_lock) begin
				if (phase == PH_LOCKED) begin
					if (take_press(KEY_UNLOCK)) begin
						relay_lvl = 1'b1;
						relay_tmr = relay_reload;
						lock_tmr  = lock_reload;
						phase     = PH_TIMING;
					end
				end else if (phase == PH_UNLOCKED) begin
					hit = take_press(KEY_UNLOCK);
					if (hit && reads_normal) begin
						phase     = PH_LOCKED;
						relay_lvl = 1'b0;
						relay_tmr = relay_reload;
					end
					if (take_press(KEY_POSITION))
						req_pos = ~req_pos;
				end
				if (phase == PH_TIMING && lock_tmr == 8'd0) begin
					pressed = 2'b00;
					phase   = PH_UNLOCKED;
				end
			end else begin
				void'(take_press(KEY_UNLOCK));
				if (take_press(KEY_POSITION))
					req_pos = ~req_pos;
			end

			matched = req_pos ? reads_reverse : reads_normal;
			if (!matched)
				motor_tmr = motor_reload;

			motor_on = motor_tmr != 8'd0;
			relay_on = relay_tmr != 8'd0;

			if (quarter) begin
				if (motor_tmr != 8'd0) motor_tmr = motor_tmr - 8'd1;
				if (relay_tmr != 8'd0) relay_tmr = relay_tmr - 8'd1;
				if (lock_tmr != 8'd0)  lock_tmr  = lock_tmr - 8'd1;
				if (phase == PH_UNLOCKED)
					leds = 2'b00;
				else if (phase == PH_TIMING)
					leds = leds ^ 2'b11;
				else
					leds = 2'b11;
			end

			if (motor_tmr == 8'd0 && relay_tmr == 8'd0 && phase == PH_LOCKED) begin
				store = 1'b1;
				hold  = 1'b0;
			end

			r.drive_normal   = ~req_pos;
			r.motor_power_on = motor_on;
			r.relay_drive    = relay_lvl;
			r.relay_power_on = relay_on;
			r.led_normal     = leds[0];
			r.led_reverse    = leds[1];
			r.hold_power     = hold;
			r.store_request  = store;
			r.store_position = req_pos;
			r.lock_status    = phase;
			owed_outputs.push_back(r);
		endfunction

		function void compare_field(string name, logic [1:0] want, logic [1:0] seen);
			if (seen !== want) begin
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, name, want, seen);
				errors++;
			end
		endfunction

		function void check_result(tlc_out_t got);
			tlc_out_t want;
			if (owed_outputs.size() == 0) begin
				$display("%0t ns: output transaction with nothing expected, expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = owed_outputs.pop_front();
			compare_field("drive_normal", {1'b0, want.drive_normal},
				{1'b0, got.drive_normal});
			compare_field("motor_power_on", {1'b0, want.motor_power_on},
				{1'b0, got.motor_power_on});
			compare_field("relay_drive", {1'b0, want.relay_drive},
				{1'b0, got.relay_drive});
			compare_field("relay_power_on", {1'b0, want.relay_power_on},
				{1'b0, got.relay_power_on});
			compare_field("led_normal", {1'b0, want.led_normal},
				{1'b0, got.led_normal});
			compare_field("led_reverse", {1'b0, want.led_reverse},
				{1'b0, got.led_reverse});
			compare_field("hold_power", {1'b0, want.hold_power},
				{1'b0, got.hold_power});
			compare_field("store_request", {1'b0, want.store_request},
				{1'b0, got.store_request});
			compare_field("store_position", {1'b0, want.store_position},
				{1'b0, got.store_position});
			compare_field("lock_status",    want.lock_status,    got.lock_status);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	tlc_in_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	tlc_out_t              out_data;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	turnout_shadow shadow;
	sense_policy_t sensor_policy;
	int            burst_left;
	int            ticks_sent;

	turnout_lock_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs a handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

	// Sample everything on the rising edge: register writes update the shadow
	// configuration, accepted output transactions are checked against the
	// oldest owed result, and accepted input transactions advance the shadow.
	// An input accepted here cannot show on the output before the next edge,
	// so the order of the three branches does not matter.
	always @(posedge clk) begin
		if (cfg_wr_en)
			shadow.write_reg(cfg_index, cfg_data);
		if (out_valid && out_ready)
			shadow.check_result(out_data);
		if (in_valid && in_ready)
			shadow.note_tick(in_data);
	end

	// Receiver: switch between stretches of steady ready, coin-flip ready,
	// heavy stalls and a regular one-in-three stall.
	initial begin
		int mode, span, k;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					0: out_ready = 1'b1;
					1: out_ready = 1'($urandom_range(0, 1));
					2: out_ready = ($urandom_range(0, 3) == 0);
					default: out_ready = (k % 3 != 0);
				endcase
			end
		end
	end

	// Build one tick: key levels as given, sensors per the scene's policy.
	function automatic tlc_in_t field_tick(bit unlock, bit position, bit simulated);
		tlc_in_t t;
		bit want_reverse;
		int roll;
		roll = $urandom_range(0, 99);
		want_reverse = (sensor_policy == SENSE_FOLLOW) ? shadow.req_pos : 1'b0;
		t.unlock_key_raw   = unlock;
		t.position_key_raw = position;
		t.simulate_lock    = simulated;
		// an occasional glitch, or the random policy, sets the sensors at random, maybe to a contradictory pair
		if (sensor_policy == SENSE_RANDOM || roll < 6) begin
			t.sense_normal  = 1'($urandom_range(0, 1));
			t.sense_reverse = 1'($urandom_range(0, 1));
		end else begin
			t.sense_normal  = ~want_reverse;
			t.sense_reverse = want_reverse;
		end
		return t;
	endfunction

	// Hold off the sender until the block has delivered every owed result.
	task automatic drain_pipeline();
		in_valid = 1'b0;
		while (shadow.owed_outputs.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Present one tick and hold it until accepted. Bursts of random length
	// are separated by random gaps; a zero gap keeps valid high unless a rare drain intervenes.
	task automatic deliver(tlc_in_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if ($urandom_range(0, 249) == 0)
				drain_pipeline();
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		in_valid = 1'b1;
		in_data  = item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		ticks_sent++;
	endtask

	task automatic hold_tick(tlc_in_t item, int count);
		repeat (count) deliver(item);
	endtask

	// Write every register, then one random unused index above the last one, which the
	// block must ignore. Only called while nothing is in flight.
	task automatic configure(logic [7:0] quarter, logic [7:0] motor, logic [7:0] relay,
			logic [7:0] timeout, logic [7:0] restore);
		cfg_wr_en = 1'b1;
		cfg_index = CFG_TICKS_PER_QUARTER;
		cfg_data  = quarter;
		@(negedge clk);
		cfg_index = CFG_MOTOR_POWER_QUARTERS;
		cfg_data  = motor;
		@(negedge clk);
		cfg_index = CFG_RELAY_POWER_QUARTERS;
		cfg_data  = relay;
		@(negedge clk);
		cfg_index = CFG_LOCK_TIMEOUT_QUARTERS;
		cfg_data  = timeout;
		@(negedge clk);
		cfg_index = CFG_RESTORED_POSITION;
		cfg_data  = restore;
		@(negedge clk);
		cfg_index = CFG_IDX_W'($urandom_range(CFG_RESTORED_POSITION + 1,
			(1 << CFG_IDX_W) - 1));
		cfg_data  = CFG_DATA_W'($urandom_range(0, 255));
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// One operator action: a clean press and release of random length (not always
	// long enough to pass the debounce), a bouncing key, or a quiet stretch that lets timers run.
	task automatic key_scene();
		scene_t scene;
		int roll, press_len, release_len;
		bit simulated;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			scene = SCENE_UNLOCK;
		else if (roll < 7)
			scene = SCENE_POSITION;
		else if (roll == 7)
			scene = SCENE_BOTH;
		else if (roll == 8)
			scene = SCENE_BOUNCE;
		else
			scene = SCENE_QUIET;
		roll = $urandom_range(0, 9);
		sensor_policy = (roll < 7) ? SENSE_FOLLOW : (roll < 9) ? SENSE_NORMAL : SENSE_RANDOM;
		simulated   = ($urandom_range(0, 99) < 85);
		press_len   = $urandom_range(3, 7);
		release_len = $urandom_range(3, 7);
		case (scene)
			SCENE_UNLOCK: begin
				repeat (press_len) deliver(field_tick(1'b1, 1'b0, simulated));
				repeat (release_len) deliver(field_tick(1'b0, 1'b0, simulated));
			end
			SCENE_POSITION: begin
				repeat (press_len) deliver(field_tick(1'b0, 1'b1, simulated));
				repeat (release_len) deliver(field_tick(1'b0, 1'b0, simulated));
			end
			SCENE_BOTH: begin
				repeat (press_len) deliver(field_tick(1'b1, 1'b1, simulated));
				repeat (release_len) deliver(field_tick(1'b0, 1'b0, simulated));
			end
			SCENE_BOUNCE: begin
				repeat (press_len)
					deliver(field_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						simulated));
			end
			default: begin
				repeat ($urandom_range(1, 30)) deliver(field_tick(1'b0, 1'b0, simulated));
			end
		endcase
	endtask

	function automatic tlc_in_t tick_of(bit unlock, bit position, bit sn, bit sr, bit simulated);
		tlc_in_t t;
		t.unlock_key_raw   = unlock;
		t.position_key_raw = position;
		t.sense_normal     = sn;
		t.sense_reverse    = sr;
		t.simulate_lock    = simulated;
		return t;
	endfunction

	initial begin
		int goal;
		shadow        = new();
		sensor_policy = SENSE_FOLLOW;
		burst_left    = 0;
		ticks_sent    = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed walk: every tick a quarter event, zero lock timeout,
		// short power timers and a reverse restored position.
		configure(8'd0, 8'd2, 8'd1, 8'd0, 8'd1);
		// all fields high: fresh debounce counters flip both keys at once,
		// the unlock press opens the lock in the same tick, sensors disagree
		hold_tick(tick_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 1);
		hold_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b1, 1'b1), 4);
		// position press while unlocked toggles to normal
		hold_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b1), 4);
		// unlock press with the turnout not normal: consumed, stays unlocked
		hold_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b1), 4);
		hold_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 1'b1), 4);
		// unlock press with the turnout normal relocks
		hold_tick(tick_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b1), 4);
		// position press while locked, too short to pass the debounce on its own
		hold_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b1), 3);
		// direct mode consumes the latch and toggles
		hold_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0), 2);
		drain_pipeline();

		// Random scenes under several settings, extremes included.
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: configure(8'd1, 8'd3, 8'd2, 8'd6, 8'($urandom_range(0, 255)));
				1: configure(8'd0, 8'd0, 8'd0, 8'd0, 8'($urandom_range(0, 255)));
				2: configure(8'd255, 8'd255, 8'd255, 8'd255, 8'($urandom_range(0, 255)));
				5: configure(8'd2, 8'd16, 8'd4, 8'd20, 8'($urandom_range(0, 255)));
				default: configure(8'($urandom_range(0, 4)), 8'($urandom_range(0, 12)),
					8'($urandom_range(0, 8)), 8'($urandom_range(0, 16)),
					8'($urandom_range(0, 255)));
			endcase
			goal = ticks_sent + ((p == 2) ? 150 : 275);
			while (ticks_sent < goal)
				key_scene();
			drain_pipeline();
		end

		// drain_pipeline has emptied the queue; give stray results a chance
		repeat (8) @(negedge clk);
		if (shadow.errors == 0 && shadow.owed_outputs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ turnout_lock_controller.f @@
src/tlc_pkg.sv
src/tlc_cfg_regs.sv
src/tlc_step.sv
src/turnout_lock_controller.sv
tb/sv/tb_turnout_lock_controller.sv
